// ----- hdl/gco_pkg.sv -----
`default_nettype none
package gco_pkg;

   localparam int MAX_VERTS  = 8;
   localparam int MAX_ITER   = 32;
   localparam int COORD_BITS = 16;

   localparam int IDX_BITS   = $clog2(MAX_VERTS);
   localparam int CNT_BITS   = $clog2(MAX_VERTS + 1);
   localparam int IT_BITS    = $clog2(MAX_ITER + 1);
   localparam int OP_W       = COORD_BITS + 4;
   localparam int MAC_W      = 2 * OP_W + 1;
   localparam int ITER_OUT_W = 6;
   localparam int ITER_SAT   = 63;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_VERT_A   = 2'd0,
      KIND_VERT_B   = 2'd1,
      KIND_CENTER_A = 2'd2,
      KIND_CENTER_B = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                      kind;
      logic signed [COORD_BITS-1:0]  x;
      logic signed [COORD_BITS-1:0]  y;
      logic                          last;
   } item_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic signed [OP_W-1:0] x;
      logic signed [OP_W-1:0] y;
   } vec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SUPA,
      ST_SUPB,
      ST_SUPEND,
      ST_LINE,
      ST_TRI_K,
      ST_TRI_AB,
      ST_TRI_AC,
      ST_DONE
   } eng_state_type;

endpackage
`default_nettype wire

// ----- hdl/gco_front.sv -----
`default_nettype none
module gco_front
   import gco_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // coord_x [15:0], coord_y [31:16]
   input  wire logic [1:0]  req_tuser,  // kind
   input  wire logic        req_tlast,
   output logic             item_valid,
   input  wire logic        item_ready,
   output item_type         item
);

   item_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]    fill_ff, fill_in;
   logic                  push, pop;
   item_type              item_w;

   assign req_tready = (fill_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign item_valid = (fill_ff != '0);
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      item_w.kind = kind_type'(req_tuser);
      item_w.x    = $signed(req_tdata[COORD_BITS-1:0]);
      item_w.y    = $signed(req_tdata[16+COORD_BITS-1:16]);
      item_w.last = req_tlast;
      wr_ptr_in   = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in   = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in     = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_w;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/gco_engine.sv -----
`default_nettype none
module gco_engine
   import gco_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   output logic            item_ready,
   input  wire item_type   item,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata
);

   eng_state_type         state_ff, state_in;
   point_type             a_vert_ff [MAX_VERTS];
   point_type             b_vert_ff [MAX_VERTS];
   logic [CNT_BITS-1:0]   cnt_a_ff, cnt_a_in;
   logic [CNT_BITS-1:0]   cnt_b_ff, cnt_b_in;
   point_type             ctr_a_ff, ctr_a_in;
   point_type             ctr_b_ff, ctr_b_in;
   vec_type               simp_ff [3];
   vec_type               simp_in [3];
   logic [1:0]            len_ff, len_in;
   vec_type               dir_ff, dir_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  first_ff, first_in;
   logic [IT_BITS-1:0]    it_ff, it_in;
   logic signed [MAC_W-1:0] best_ff, best_in;
   point_type             best_a_ff, best_a_in;
   point_type             best_b_ff, best_b_in;
   logic                  k_pos_ff, k_pos_in, k_neg_ff, k_neg_in;
   logic                  res_hit_ff, res_hit_in, res_quit_ff, res_quit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;

   logic signed [OP_W-1:0]  m0a, m0b, m1a, m1b;
   logic signed [2*OP_W-1:0] p0, p1;
   logic signed [MAC_W-1:0] mac;
   vec_type               sup_p, ab, ac, ao, abp, acp;
   point_type             cur_a, cur_b;
   logic                  last_a, last_b, at_limit, out_free;
   logic                  store;
   logic [ITER_OUT_W-1:0] iter_out;

   assign item_ready = (state_ff == ST_IDLE);
   assign store      = item_valid && item_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cur_a  = a_vert_ff[idx_ff];
      cur_b  = b_vert_ff[idx_ff];
      last_a = ((CNT_BITS)'(idx_ff) + 1'b1) == cnt_a_ff;
      last_b = ((CNT_BITS)'(idx_ff) + 1'b1) == cnt_b_ff;
      sup_p.x = OP_W'(best_a_ff.x) - OP_W'(best_b_ff.x);
      sup_p.y = OP_W'(best_a_ff.y) - OP_W'(best_b_ff.y);
      if (len_ff == 2'd2) begin
         ab.x = simp_ff[0].x - simp_ff[1].x;
         ab.y = simp_ff[0].y - simp_ff[1].y;
         ac   = ab;
         ao.x = -simp_ff[1].x;
         ao.y = -simp_ff[1].y;
      end else begin
         ab.x = simp_ff[1].x - simp_ff[2].x;
         ab.y = simp_ff[1].y - simp_ff[2].y;
         ac.x = simp_ff[0].x - simp_ff[2].x;
         ac.y = simp_ff[0].y - simp_ff[2].y;
         ao.x = -simp_ff[2].x;
         ao.y = -simp_ff[2].y;
      end
      // perpendicular toward the side the triple product points to
      abp = '0;
      if (k_pos_ff) begin
         abp.x = -ab.y;
         abp.y = ab.x;
      end else if (k_neg_ff) begin
         abp.x = ab.y;
         abp.y = -ab.x;
      end
      acp = '0;
      if (k_neg_ff) begin
         acp.x = -ac.y;
         acp.y = ac.x;
      end else if (k_pos_ff) begin
         acp.x = ac.y;
         acp.y = -ac.x;
      end
      at_limit = (it_ff == IT_BITS'(MAX_ITER));
   end

   // shared multiply-add unit
   always_comb begin
      m0a = '0;
      m0b = '0;
      m1a = '0;
      m1b = '0;
      case (state_ff)
         ST_SUPA: begin
            m0a = OP_W'(cur_a.x); m0b = dir_ff.x;
            m1a = OP_W'(cur_a.y); m1b = dir_ff.y;
         end
         ST_SUPB: begin
            m0a = OP_W'(cur_b.x); m0b = dir_ff.x;
            m1a = OP_W'(cur_b.y); m1b = dir_ff.y;
         end
         ST_SUPEND: begin
            m0a = sup_p.x; m0b = dir_ff.x;
            m1a = sup_p.y; m1b = dir_ff.y;
         end
         ST_LINE: begin
            m0a = ab.x;  m0b = ao.y;
            m1a = -ab.y; m1b = ao.x;
         end
         ST_TRI_K: begin
            m0a = ac.x;  m0b = ab.y;
            m1a = -ac.y; m1b = ab.x;
         end
         ST_TRI_AB: begin
            m0a = abp.x; m0b = ao.x;
            m1a = abp.y; m1b = ao.y;
         end
         ST_TRI_AC: begin
            m0a = acp.x; m0b = ao.x;
            m1a = acp.y; m1b = ao.y;
         end
         default: begin
         end
      endcase
      p0  = m0a * m0b;
      p1  = m1a * m1b;
      mac = MAC_W'(p0) + MAC_W'(p1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (store && item.last) state_in = ST_START;
         ST_START:  state_in = (cnt_a_ff == '0 || cnt_b_ff == '0) ? ST_DONE : ST_SUPA;
         ST_SUPA:   if (last_a) state_in = ST_SUPB;
         ST_SUPB:   if (last_b) state_in = ST_SUPEND;
         ST_SUPEND: begin
            if (first_ff) begin
               state_in = ST_SUPA;
            end else if (mac < 0) begin
               state_in = ST_DONE;
            end else begin
               state_in = (len_ff == 2'd1) ? ST_LINE : ST_TRI_K;
            end
         end
         ST_LINE: begin
            if (mac == '0 || at_limit) state_in = ST_DONE;
            else state_in = ST_SUPA;
         end
         ST_TRI_K:  state_in = ST_TRI_AB;
         ST_TRI_AB: begin
            if (mac > 0) state_in = at_limit ? ST_DONE : ST_SUPA;
            else state_in = ST_TRI_AC;
         end
         ST_TRI_AC: begin
            if (mac > 0 && !at_limit) state_in = ST_SUPA;
            else state_in = ST_DONE;
         end
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_a_in    = cnt_a_ff;
      cnt_b_in    = cnt_b_ff;
      ctr_a_in    = ctr_a_ff;
      ctr_b_in    = ctr_b_ff;
      simp_in     = simp_ff;
      len_in      = len_ff;
      dir_in      = dir_ff;
      idx_in      = idx_ff;
      first_in    = first_ff;
      it_in       = it_ff;
      best_in     = best_ff;
      best_a_in   = best_a_ff;
      best_b_in   = best_b_ff;
      k_pos_in    = k_pos_ff;
      k_neg_in    = k_neg_ff;
      res_hit_in  = res_hit_ff;
      res_quit_in = res_quit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (int'(it_ff) > ITER_SAT) begin
         iter_out = ITER_OUT_W'(ITER_SAT);
      end else begin
         iter_out = ITER_OUT_W'(it_ff);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (store) begin
               case (item.kind)
                  KIND_VERT_A: if (cnt_a_ff != CNT_BITS'(MAX_VERTS)) cnt_a_in = cnt_a_ff + 1'b1;
                  KIND_VERT_B: if (cnt_b_ff != CNT_BITS'(MAX_VERTS)) cnt_b_in = cnt_b_ff + 1'b1;
                  KIND_CENTER_A: begin
                     ctr_a_in.x = item.x;
                     ctr_a_in.y = item.y;
                  end
                  default: begin
                     ctr_b_in.x = item.x;
                     ctr_b_in.y = item.y;
                  end
               endcase
            end
         end
         ST_START: begin
            dir_in.x    = OP_W'(ctr_b_ff.x) - OP_W'(ctr_a_ff.x);
            dir_in.y    = OP_W'(ctr_b_ff.y) - OP_W'(ctr_a_ff.y);
            first_in    = 1'b1;
            idx_in      = '0;
            it_in       = '0;
            len_in      = '0;
            res_hit_in  = 1'b0;
            res_quit_in = 1'b0;
         end
         ST_SUPA: begin
            if (idx_ff == '0 || mac > best_ff) begin
               best_in   = mac;
               best_a_in = cur_a;
            end
            idx_in = last_a ? '0 : idx_ff + 1'b1;
         end
         ST_SUPB: begin
            // furthest along -d is the smallest dot along d
            if (idx_ff == '0 || mac < best_ff) begin
               best_in   = mac;
               best_b_in = cur_b;
            end
            idx_in = last_b ? '0 : idx_ff + 1'b1;
         end
         ST_SUPEND: begin
            if (first_ff) begin
               first_in   = 1'b0;
               simp_in[0] = sup_p;
               len_in     = 2'd1;
               dir_in.x   = -sup_p.x;
               dir_in.y   = -sup_p.y;
            end else begin
               it_in = it_ff + 1'b1;
               if (mac >= 0) begin
                  simp_in[len_ff] = sup_p;
                  len_in = len_ff + 1'b1;
               end
            end
         end
         ST_LINE: begin
            if (mac == '0) begin
               res_hit_in = 1'b1;
            end else begin
               if (mac > 0) begin
                  dir_in.x = -ab.y;
                  dir_in.y = ab.x;
               end else begin
                  dir_in.x = ab.y;
                  dir_in.y = -ab.x;
               end
               res_quit_in = at_limit;
            end
         end
         ST_TRI_K: begin
            k_pos_in = (mac > 0);
            k_neg_in = (mac < 0);
         end
         ST_TRI_AB: begin
            if (mac > 0) begin
               simp_in[0]  = simp_ff[1];
               simp_in[1]  = simp_ff[2];
               len_in      = 2'd2;
               dir_in      = abp;
               res_quit_in = at_limit;
            end
         end
         ST_TRI_AC: begin
            if (mac > 0) begin
               simp_in[1]  = simp_ff[2];
               len_in      = 2'd2;
               dir_in      = acp;
               res_quit_in = at_limit;
            end else begin
               res_hit_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {iter_out, res_quit_ff, res_hit_ff};
               cnt_a_in     = '0;
               cnt_b_in     = '0;
               ctr_a_in     = '0;
               ctr_b_in     = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ctr_a_ff     <= '0;
         ctr_b_ff     <= '0;
         dir_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         it_ff        <= '0;
         res_hit_ff   <= 1'b0;
         res_quit_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ctr_a_ff     <= ctr_a_in;
         ctr_b_ff     <= ctr_b_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
         it_ff        <= it_in;
         res_hit_ff   <= res_hit_in;
         res_quit_ff  <= res_quit_in;
      end
   end

   always_ff @(posedge clock) begin
      simp_ff     <= simp_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      first_ff    <= first_in;
      best_ff     <= best_in;
      best_a_ff   <= best_a_in;
      best_b_ff   <= best_b_in;
      k_pos_ff    <= k_pos_in;
      k_neg_ff    <= k_neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (store && item.kind == KIND_VERT_A && cnt_a_ff != CNT_BITS'(MAX_VERTS)) begin
         a_vert_ff[cnt_a_ff[IDX_BITS-1:0]] <= '{x: item.x, y: item.y};
      end
      if (store && item.kind == KIND_VERT_B && cnt_b_ff != CNT_BITS'(MAX_VERTS)) begin
         b_vert_ff[cnt_b_ff[IDX_BITS-1:0]] <= '{x: item.x, y: item.y};
      end
   end

endmodule
`default_nettype wire

// ----- hdl/gjk_convex_polygon_overlap.sv -----
// a point word enters the input queue, and the engine takes it from the queue only while idle
// after a last word is stored the engine runs its support passes over the na and nb vertices
// of both polygons, and its result word is held while rsp_tready is low
// one vertex per cycle goes through the shared multiply-add during each support search
// throughput: one query at a time; a four-word queue takes input while a test runs
// reset: synchronous, clears the queue, counts, centers and the result valid flag
`default_nettype none
module gjk_convex_polygon_overlap
   import gco_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // coord_x [15:0], coord_y [31:16]
   input  wire logic [1:0]  req_tuser,  // kind
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata   // collide [0], gave_up [1], iterations [7:2]
);

   logic     item_valid;
   logic     item_ready;
   item_type item;

   gco_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   gco_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- verif/tb_gjk_convex_polygon_overlap.sv -----
`timescale 1ns / 1ps
module tb_gjk_convex_polygon_overlap;
   import gco_pkg::*;

   typedef struct {
      bit       collide;
      bit       gave_up;
      bit [5:0] iterations;
   } verdict_type;

   typedef struct {
      longint x;
      longint y;
   } pt_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;

   verdict_type verdict_q[$];
   int       error_count = 0;
   longint   cycle_count = 0;

   // predictor state
   pt_type poly_a[MAX_VERTS];
   pt_type poly_b[MAX_VERTS];
   int     n_a = 0;
   int     n_b = 0;
   pt_type ctr_a = '{0, 0};
   pt_type ctr_b = '{0, 0};
   pt_type splx[3];
   int     splx_len;
   pt_type dir;

   gjk_convex_polygon_overlap uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic longint dotp(pt_type p, pt_type q);
      return p.x * q.x + p.y * q.y;
   endfunction

   function automatic longint crossp(pt_type p, pt_type q);
      return p.x * q.y - p.y * q.x;
   endfunction

   function automatic pt_type minus(pt_type p, pt_type q);
      pt_type r;
      r.x = p.x - q.x;
      r.y = p.y - q.y;
      return r;
   endfunction

   // sign-correct replacement for the triple product (p x q) x e
   function automatic pt_type normal_toward(pt_type p, pt_type q, pt_type e);
      longint k;
      pt_type r;
      k = crossp(p, q);
      r = '{0, 0};
      if (k > 0) r = '{-e.y, e.x};
      else if (k < 0) r = '{e.y, -e.x};
      return r;
   endfunction

   function automatic pt_type extreme(bit use_b, pt_type d);
      pt_type best;
      longint bd;
      longint v;
      int     n;
      n = use_b ? n_b : n_a;
      best = use_b ? poly_b[0] : poly_a[0];
      bd = dotp(best, d);
      for (int i = 1; i < n; i++) begin
         v = dotp(use_b ? poly_b[i] : poly_a[i], d);
         if (v > bd) begin
            bd = v;
            best = use_b ? poly_b[i] : poly_a[i];
         end
      end
      return best;
   endfunction

   function automatic pt_type minkowski_support(pt_type d);
      pt_type nd;
      nd = '{-d.x, -d.y};
      return minus(extreme(0, d), extreme(1, nd));
   endfunction

   function automatic bit shrink_simplex();
      pt_type a, b, c, ab, ac, ao, abp, acp, o;
      o = '{0, 0};
      if (splx_len == 2) begin
         b = splx[0];
         a = splx[1];
         ab = minus(b, a);
         ao = minus(o, a);
         if (crossp(ab, ao) == 0) return 1;
         dir = normal_toward(ab, ao, ab);
         return 0;
      end
      c = splx[0];
      b = splx[1];
      a = splx[2];
      ab = minus(b, a);
      ac = minus(c, a);
      ao = minus(o, a);
      abp = normal_toward(ac, ab, ab);
      if (dotp(abp, ao) > 0) begin
         splx[0] = b;
         splx[1] = a;
         splx_len = 2;
         dir = abp;
         return 0;
      end
      acp = normal_toward(ab, ac, ac);
      if (dotp(acp, ao) > 0) begin
         splx[0] = c;
         splx[1] = a;
         splx_len = 2;
         dir = acp;
         return 0;
      end
      return 1;
   endfunction

   function automatic verdict_type overlap_verdict();
      verdict_type r;
      pt_type   p;
      bit       hit, miss;
      int       used;
      r = '{0, 0, 0};
      hit = 0;
      miss = 0;
      used = 0;
      if (n_a == 0 || n_b == 0) return r;
      dir = minus(ctr_b, ctr_a);
      splx[0] = minkowski_support(dir);
      splx_len = 1;
      dir = '{-splx[0].x, -splx[0].y};
      for (int it = 1; it <= MAX_ITER; it++) begin
         p = minkowski_support(dir);
         used = it;
         if (dotp(p, dir) < 0) begin
            miss = 1;
            break;
         end
         if (splx_len < 3) begin
            splx[splx_len] = p;
            splx_len++;
         end
         if (shrink_simplex()) begin
            hit = 1;
            break;
         end
      end
      r.collide = hit;
      r.gave_up = !hit && !miss;
      r.iterations = (used > ITER_SAT) ? 6'(ITER_SAT) : 6'(used);
      return r;
   endfunction

   function automatic void absorb_point(kind_type k, logic signed [15:0] x,
                                        logic signed [15:0] y, bit lst);
      pt_type p;
      p.x = x;
      p.y = y;
      case (k)
         KIND_VERT_A: begin
            if (n_a < MAX_VERTS) begin
               poly_a[n_a] = p;
               n_a++;
            end
         end
         KIND_VERT_B: begin
            if (n_b < MAX_VERTS) begin
               poly_b[n_b] = p;
               n_b++;
            end
         end
         KIND_CENTER_A: ctr_a = p;
         default: ctr_b = p;
      endcase
      if (lst) begin
         verdict_q.insert(verdict_q.size(), overlap_verdict());
         n_a = 0;
         n_b = 0;
         ctr_a = '{0, 0};
         ctr_b = '{0, 0};
      end
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_point(kind_type k, logic signed [15:0] x, logic signed [15:0] y,
                             bit lst);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {y, x};
      req_tuser <= k;
      req_tlast <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_point(k, x, y, lst);
   endtask

   function automatic logic signed [15:0] rnd_coord(int span);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 16'sh7fff;
      if (r == 1) return 16'sh8000;
      if (r == 2) return 16'($urandom());
      return 16'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // well-formed query: two small polygons around random centers, maybe overlapping
   task automatic send_query(int span);
      int cax, cay, cbx, cby, na, nb, rad;
      int ang;
      bit lst;
      cax = $urandom_range(0, 2 * span) - span;
      cay = $urandom_range(0, 2 * span) - span;
      cbx = cax + $urandom_range(0, span) - span / 2;
      cby = cay + $urandom_range(0, span) - span / 2;
      na = $urandom_range(1, MAX_VERTS + 1);
      nb = $urandom_range(1, MAX_VERTS + 1);
      rad = $urandom_range(1, span / 2 + 1);
      send_point(KIND_CENTER_A, 16'(cax), 16'(cay), 0);
      send_point(KIND_CENTER_B, 16'(cbx), 16'(cby), 0);
      for (int i = 0; i < na; i++) begin
         ang = $urandom_range(0, 3);
         send_point(KIND_VERT_A, 16'(cax + (ang[0] ? rad : -rad) + $urandom_range(0, 3)),
                    16'(cay + (ang[1] ? rad : -rad) + $urandom_range(0, 3)), 0);
      end
      for (int i = 0; i < nb; i++) begin
         ang = $urandom_range(0, 3);
         lst = (i == nb - 1);
         send_point(KIND_VERT_B, 16'(cbx + (ang[0] ? rad : -rad) + $urandom_range(0, 3)),
                    16'(cby + (ang[1] ? rad : -rad) + $urandom_range(0, 3)), lst);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_directed();
      // empty shapes
      send_point(KIND_VERT_A, 16'sd5, 16'sd5, 1);
      send_point(KIND_VERT_B, 16'sd5, 16'sd5, 1);
      // identical points touching at origin difference
      send_point(KIND_VERT_A, 16'sd0, 16'sd0, 0);
      send_point(KIND_VERT_B, 16'sd0, 16'sd0, 1);
      // extreme corners, a full-range square over a short segment
      send_point(KIND_VERT_A, 16'sh8000, 16'sh8000, 0);
      send_point(KIND_VERT_A, 16'sh7fff, 16'sh8000, 0);
      send_point(KIND_VERT_A, 16'sh7fff, 16'sh7fff, 0);
      send_point(KIND_VERT_A, 16'sh8000, 16'sh7fff, 0);
      send_point(KIND_CENTER_A, 16'sh7fff, 16'sh8000, 0);
      send_point(KIND_CENTER_B, 16'sh8000, 16'sh7fff, 0);
      send_point(KIND_VERT_B, 16'sd0, 16'sd0, 0);
      send_point(KIND_VERT_B, 16'sd1, 16'sd0, 1);
      // far apart, a miss
      send_point(KIND_VERT_A, 16'sh7fff, 16'sh7fff, 0);
      send_point(KIND_VERT_B, 16'sh8000, 16'sh8000, 1);
      // vertex overflow: ten vertices of a
      for (int i = 0; i < 10; i++)
         send_point(KIND_VERT_A, 16'(i * 3 - 10), 16'(i * i - 20), 0);
      send_point(KIND_VERT_B, 16'sd1, 16'sd1, 1);
      wait_drained();
   endtask

   task automatic test_random_queries();
      for (int q = 0; q < 30; q++)
         send_query(($urandom_range(0, 9) == 0) ? 12000 : 40);
      wait_drained();
   endtask

   task automatic test_random_noise();
      kind_type k;
      for (int i = 0; i < 150; i++) begin
         k = kind_type'($urandom_range(0, 3));
         send_point(k, rnd_coord(50), rnd_coord(50), $urandom_range(0, 7) == 0);
      end
      send_point(KIND_VERT_B, rnd_coord(50), rnd_coord(50), 1);
      wait_drained();
   endtask

   always @(posedge clock) begin
      verdict_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_tdata[0] !== want.collide) begin
                  $display("%0t: collide expected %0d actual %0d", $time, want.collide,
                           rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[1] !== want.gave_up) begin
                  $display("%0t: gave_up expected %0d actual %0d", $time, want.gave_up,
                           rsp_tdata[1]);
                  error_count++;
               end
               if (rsp_tdata[7:2] !== want.iterations) begin
                  $display("%0t: iterations expected %0d actual %0d", $time,
                           want.iterations, rsp_tdata[7:2]);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver stalls, with quiet stretches of always ready
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset) rsp_tready <= 1'b0;
      else if ((cycle_count / 2000) % 3 == 0) rsp_tready <= 1'b1;
      else if (r < 60) rsp_tready <= 1'b1;
      else if (r < 97) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 3) == 0);
   end

   always @(posedge clock) begin
      if (cycle_count > 1500000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_VERT_A;
      req_tlast = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_queries();
      test_random_noise();
      test_random_queries();
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && verdict_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
